>>> src/ktsr_pkg.sv
// Shared types and codes for the keyed table with swap-on-remove.
`default_nettype none

package ktsr_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int ENTRIES_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP   = 2'd0,
        OP_INSERT   = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MISSING   = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VALUE_W-1:0]   found_value;
        logic [SLOT_W-1:0]    slot;
        logic [ENTRIES_W-1:0] entries;
    } rsp_t;

endpackage

`default_nettype wire

>>> src/ktsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ktsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/keyed_table_swap_remove_unit.sv
// Keyed table of unique keys with swap-on-remove: top level.
//
// Request word (req): op, key, value; taken when req_valid is high and
// req_stall low. One request is handled at a time; req_stall stays high
// from acceptance until the result has been moved into the output register.
// Response word (rsp): status, found_value, slot, entries; offered on
// rsp_valid and held unchanged while rsp_stall is high. The output register
// frees the table to take the next request while a response waits.
// The scan walks the key RAM, which has registered read data, one slot per
// cycle, and stops at the first matching key or after the last live entry.
// A remove then fetches the last entry and writes it into the freed slot.
// req_stall falls in the same cycle that rsp_valid rises, so the next request
// can be taken while the response is offered; each request is finished
// before the next one is taken.
// Reset empties the table at once (entry count to zero); the RAM contents
// are left as they are, since slots beyond the count are never read.
// If the receiver stalls, the finished response is held and the next
// request finishes its scan and then waits for the output register.
`default_nettype none

module keyed_table_swap_remove_unit
    import ktsr_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_MOVE,
        S_DONE
    } state_t;

    state_t                 state_reg;
    op_t                    op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          scan_idx_reg;
    logic                   cmp_valid_reg;
    logic [AW-1:0]          cmp_idx_reg;
    logic [AW-1:0]          pos_reg;
    status_t                status_reg;
    logic [VALUE_W-1:0]     fval_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    logic                   key_we;
    logic                   val_we;
    logic [AW-1:0]          wr_addr;
    logic [KEY_WIDTH-1:0]   key_wdata;
    logic [VALUE_WIDTH-1:0] val_wdata;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [KEY_WIDTH-1:0]   key_rdata;
    logic [VALUE_WIDTH-1:0] val_rdata;

    logic                   hit_now;
    logic                   issue;
    logic                   miss_now;
    logic                   full;
    logic [CW-1:0]          last_idx;
    logic                   out_free;

    ktsr_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (wr_addr),
        .wr_data (key_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rdata)
    );

    ktsr_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (wr_addr),
        .wr_data (val_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    always_comb
    begin
        hit_now  = cmp_valid_reg && (key_rdata == key_reg);
        issue    = (state_reg == S_SCAN) && !hit_now && (scan_idx_reg < count_reg);
        miss_now = (state_reg == S_SCAN) && !cmp_valid_reg && (scan_idx_reg >= count_reg);
        full     = (count_reg == CW'(CAPACITY));
        last_idx = count_reg - CW'(1);
        out_free = !rsp_valid_reg || !rsp_stall;

        rd_en   = issue || (state_reg == S_FETCH);
        rd_addr = (state_reg == S_FETCH) ? last_idx[AW-1:0] : scan_idx_reg[AW-1:0];

        key_we    = 1'b0;
        wr_addr   = count_reg[AW-1:0];
        key_wdata = key_reg;
        val_wdata = value_reg;
        if (state_reg == S_MOVE)
        begin
            key_we    = 1'b1;
            wr_addr   = pos_reg;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
        end
        else if (miss_now && (op_reg == OP_INSERT) && !full)
        begin
            key_we = 1'b1;
        end
        val_we = key_we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_LOOKUP;
            key_reg       <= '0;
            value_reg     <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            pos_reg       <= '0;
            status_reg    <= ST_OK;
            fval_reg      <= '0;
            slot_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg        <= op_t'(req.op);
                        key_reg       <= KEY_WIDTH'(req.key);
                        value_reg     <= VALUE_WIDTH'(req.value);
                        scan_idx_reg  <= '0;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    cmp_valid_reg <= issue;
                    cmp_idx_reg   <= scan_idx_reg[AW-1:0];
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + CW'(1);
                    end

                    if (hit_now)
                    begin
                        slot_reg <= SLOT_W'(cmp_idx_reg);
                        pos_reg  <= cmp_idx_reg;
                        unique case (op_reg)
                            OP_INSERT:
                            begin
                                status_reg <= ST_DUPLICATE;
                                fval_reg   <= '0;
                                state_reg  <= S_DONE;
                            end
                            OP_REMOVE:
                            begin
                                status_reg <= ST_OK;
                                fval_reg   <= VALUE_W'(val_rdata);
                                state_reg  <= S_FETCH;
                            end
                            default:
                            begin
                                status_reg <= ST_OK;
                                fval_reg   <= VALUE_W'(val_rdata);
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                    else if (miss_now)
                    begin
                        fval_reg  <= '0;
                        state_reg <= S_DONE;
                        priority if (op_reg == OP_INSERT && full)
                        begin
                            status_reg <= ST_FULL;
                            slot_reg   <= '0;
                        end
                        else if (op_reg == OP_INSERT)
                        begin
                            status_reg <= ST_OK;
                            slot_reg   <= SLOT_W'(count_reg[AW-1:0]);
                            count_reg  <= count_reg + CW'(1);
                        end
                        else
                        begin
                            status_reg <= ST_MISSING;
                            slot_reg   <= '0;
                        end
                    end
                end

                S_FETCH:
                begin
                    state_reg <= S_MOVE;
                end

                S_MOVE:
                begin
                    count_reg <= last_idx;
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg.status      <= status_reg;
                        rsp_reg.found_value <= fval_reg;
                        rsp_reg.slot        <= slot_reg;
                        rsp_reg.entries     <= ENTRIES_W'(count_reg);
                        state_reg           <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> src/ktsr_checker.sv
// Port-level checks for the keyed table, bound to the top level.
`default_nettype none

module ktsr_checker
    import ktsr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // stalled response word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

    // stalled request word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request word changed");

    // one request at a time: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |->
            (rsp.entries == ENTRIES_W'(CAPACITY)) && (rsp.slot == '0)
            && (rsp.found_value == '0))
    else $error("full status with table not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_MISSING) |->
            (rsp.found_value == '0) && (rsp.slot == '0))
    else $error("miss response carries data");

endmodule

bind keyed_table_swap_remove_unit ktsr_checker #(
    .CAPACITY (CAPACITY)
) u_ktsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
